// File: design/salc_pkg.sv
package salc_pkg;

   localparam int DEF_MAX_SETS = 64;
   localparam int DEF_MAX_WAYS = 8;

   localparam int ADDR_W  = 64;
   localparam int TAG_W   = 64;
   localparam int STAMP_W = 32;
   localparam int TOTAL_W = 32;

   // access kinds
   localparam logic [1:0] ACT_FETCH  = 2'd0;
   localparam logic [1:0] ACT_LOAD   = 2'd1;
   localparam logic [1:0] ACT_STORE  = 2'd2;
   localparam logic [1:0] ACT_MODIFY = 2'd3;

   // register indexes
   localparam int CSR_IDX_W = 2;
   localparam int CSR_DATA_W = 6;
   localparam logic [CSR_IDX_W-1:0] CSR_SET_BITS   = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_BLOCK_BITS = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_WAYS       = 2'd2;

   typedef struct packed {
      logic [1:0]        action;
      logic [ADDR_W-1:0] address;
   } req_type;

   typedef struct packed {
      logic [1:0]         hit_count;
      logic               missed;
      logic               evicted;
      logic               ignored;
      logic [TOTAL_W-1:0] total_hits;
      logic [TOTAL_W-1:0] total_misses;
      logic [TOTAL_W-1:0] total_evictions;
   } rsp_type;

   typedef struct packed {
      logic                valid;
      logic [TAG_W-1:0]    tag;
      logic [STAMP_W-1:0]  stamp;
   } line_type;

   typedef struct packed {
      logic hit;
      logic evicted;
   } sel_type;

endpackage

// File: design/set_assoc_lru_cache_model.sv
// Set-associative cache model with LRU replacement.
// req channel: one beat per access (action, address); accepted when req_valid
// is high and req_stall is low. rsp channel: one beat per accepted access with
// hit count, miss/evict/ignored flags and the saturating running totals.
// csr channel: register writes (set bits, block bits, ways in use) by index;
// csr_ready is always high. Write only while no access is in flight.
// Timing: an access is accepted with its set row read from the line RAM into a
// register, then compared and written back in the lookup state, where its
// response beat is loaded. One access is in flight at a time, so the next one
// can be taken only after the lookup state has finished with the current one.
// A response beat waiting under rsp_stall does not block acceptance of the
// next access; that access then holds in its compare step until the output
// register frees up.
// Reset: synchronous. After reset the line RAM is swept clear, one set per
// cycle; req_stall stays high during the sweep.
// Registers reset to set bits 1, block bits 1, ways in use 1.
module set_assoc_lru_cache_model
   import salc_pkg::*;
#(
   parameter int MAX_SETS = DEF_MAX_SETS,
   parameter int MAX_WAYS = DEF_MAX_WAYS
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_stall,
   input  req_type               req_data,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output rsp_type               rsp_data,
   input  logic                  csr_valid,
   output logic                  csr_ready,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_data
);

   localparam int SET_W  = (MAX_SETS > 1) ? $clog2(MAX_SETS) : 1;
   localparam int WCNT_W = $clog2(MAX_WAYS + 1);

   typedef enum logic [2:0] {
      ST_CLEAR  = 3'b001,
      ST_IDLE   = 3'b010,
      ST_LOOKUP = 3'b100
   } state_type;

   state_type state_ff, state_in;

   logic [2:0] set_bits_ff;
   logic [5:0] block_bits_ff;
   logic [3:0] ways_ff;

   logic [SET_W-1:0]   clr_addr_ff, clr_addr_in;
   logic [1:0]         act_ff, act_in;
   logic [TAG_W-1:0]   tag_ff, tag_in;
   logic [SET_W-1:0]   set_ff, set_in;
   logic [STAMP_W-1:0] stamp_ff, stamp_in;
   logic [TOTAL_W-1:0] hits_ff, hits_in;
   logic [TOTAL_W-1:0] misses_ff, misses_in;
   logic [TOTAL_W-1:0] evicts_ff, evicts_in;
   logic               rsp_valid_ff, rsp_valid_in;
   rsp_type            rsp_ff, rsp_in;

   logic                  accept;
   logic                  finish;
   logic [6:0]            tag_shift;
   logic [6:0]            set_raw;
   logic [SET_W-1:0]      set_index;
   logic [TAG_W-1:0]      lookup_tag;
   logic [WCNT_W-1:0]     ways_eff;
   logic [31:0]           ways_wide;
   logic                  is_fetch;
   logic [1:0]            hit_count;
   line_type [MAX_WAYS-1:0] rd_row;
   line_type [MAX_WAYS-1:0] new_row;
   line_type [MAX_WAYS-1:0] wr_row;
   logic                  wr_en;
   logic [SET_W-1:0]      wr_addr;
   sel_type               sel;

   function automatic logic [SET_W-1:0] wrap_set(input logic [6:0] raw);
      logic [31:0] r;
      r = {25'd0, raw};
      for (int j = 6; j >= 0; j--) begin
         if (r >= 32'(MAX_SETS << j)) begin
            r = r - 32'(MAX_SETS << j);
         end
      end
      return r[SET_W-1:0];
   endfunction

   function automatic logic [TOTAL_W-1:0] sat_add(input logic [TOTAL_W-1:0] a,
                                                  input logic [1:0] b);
      logic [TOTAL_W:0] s;
      s = {1'b0, a} + (TOTAL_W+1)'(b);
      return s[TOTAL_W] ? '1 : s[TOTAL_W-1:0];
   endfunction

   // config registers
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         set_bits_ff   <= 3'd1;
         block_bits_ff <= 6'd1;
         ways_ff       <= 4'd1;
      end else if (csr_valid && csr_ready) begin
         unique case (csr_index)
            CSR_SET_BITS:   set_bits_ff   <= csr_data[2:0];
            CSR_BLOCK_BITS: block_bits_ff <= csr_data;
            CSR_WAYS:       ways_ff       <= csr_data[3:0];
            default: ;
         endcase
      end
   end

   // address split
   always_comb begin
      tag_shift  = 7'(set_bits_ff) + 7'(block_bits_ff);
      lookup_tag = (tag_shift >= 7'd64) ? '0 : (req_data.address >> tag_shift);
      set_raw    = 7'(req_data.address >> block_bits_ff) &
                   7'((8'd1 << set_bits_ff) - 8'd1);
      set_index  = wrap_set(set_raw);
   end

   // associativity clamp
   assign ways_wide = {28'd0, ways_ff};
   always_comb begin
      priority if (ways_ff == 4'd0) begin
         ways_eff = WCNT_W'(1);
      end else if (ways_wide > 32'(MAX_WAYS)) begin
         ways_eff = WCNT_W'(MAX_WAYS);
      end else begin
         ways_eff = ways_wide[WCNT_W-1:0];
      end
   end

   assign req_stall = (state_ff != ST_IDLE);
   assign accept    = req_valid && !req_stall;
   assign finish    = (state_ff == ST_LOOKUP) && (!rsp_valid_ff || !rsp_stall);
   assign is_fetch  = (act_ff == ACT_FETCH);

   salc_line_ram #(
      .DEPTH (MAX_SETS),
      .WAYS  (MAX_WAYS)
   ) u_ram (
      .clock   (clock),
      .rd_en   (accept),
      .rd_addr (set_index),
      .rd_data (rd_row),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_row)
   );

   salc_way_select #(
      .MAX_WAYS (MAX_WAYS)
   ) u_sel (
      .row_in     (rd_row),
      .lookup_tag (tag_ff),
      .stamp_now  (stamp_ff),
      .ways_eff   (ways_eff),
      .row_out    (new_row),
      .status     (sel)
   );

   // RAM write: clearing sweep or write-back of the looked-up set
   always_comb begin
      if (state_ff == ST_CLEAR) begin
         wr_en   = 1'b1;
         wr_addr = clr_addr_ff;
         wr_row  = '0;
      end else begin
         wr_en   = finish && !is_fetch;
         wr_addr = set_ff;
         wr_row  = new_row;
      end
   end

   always_comb begin
      hit_count = '0;
      if (!is_fetch) begin
         hit_count = {1'b0, sel.hit} + ((act_ff == ACT_MODIFY) ? 2'd1 : 2'd0);
      end
   end

   always_comb begin
      state_in     = state_ff;
      clr_addr_in  = clr_addr_ff;
      act_in       = act_ff;
      tag_in       = tag_ff;
      set_in       = set_ff;
      stamp_in     = stamp_ff;
      hits_in      = hits_ff;
      misses_in    = misses_ff;
      evicts_in    = evicts_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_in       = rsp_ff;

      unique case (state_ff)
         ST_CLEAR: begin
            clr_addr_in = clr_addr_ff + SET_W'(1);
            if (clr_addr_ff == SET_W'(MAX_SETS - 1)) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (accept) begin
               act_in   = req_data.action;
               tag_in   = lookup_tag;
               set_in   = set_index;
               state_in = ST_LOOKUP;
            end
         end
         ST_LOOKUP: begin
            if (finish) begin
               if (!is_fetch) begin
                  stamp_in  = stamp_ff + STAMP_W'(1);
                  hits_in   = sat_add(hits_ff, hit_count);
                  misses_in = sat_add(misses_ff, {1'b0, !sel.hit});
                  evicts_in = sat_add(evicts_ff, {1'b0, sel.evicted});
               end
               rsp_valid_in           = 1'b1;
               rsp_in.hit_count       = hit_count;
               rsp_in.missed          = !is_fetch && !sel.hit;
               rsp_in.evicted         = !is_fetch && sel.evicted;
               rsp_in.ignored         = is_fetch;
               rsp_in.total_hits      = hits_in;
               rsp_in.total_misses    = misses_in;
               rsp_in.total_evictions = evicts_in;
               state_in               = ST_IDLE;
            end
         end
         default: state_in = ST_CLEAR;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         clr_addr_ff  <= '0;
         stamp_ff     <= '0;
         hits_ff      <= '0;
         misses_ff    <= '0;
         evicts_ff    <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_addr_ff  <= clr_addr_in;
         stamp_ff     <= stamp_in;
         hits_ff      <= hits_in;
         misses_ff    <= misses_in;
         evicts_ff    <= evicts_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      act_ff <= act_in;
      tag_ff <= tag_in;
      set_ff <= set_in;
      rsp_ff <= rsp_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule

// File: design/salc_line_ram.sv
module salc_line_ram
   import salc_pkg::*;
#(
   parameter int DEPTH = DEF_MAX_SETS,
   parameter int WAYS  = DEF_MAX_WAYS,
   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic                       clock,
   input  logic                       rd_en,
   input  logic [AW-1:0]              rd_addr,
   output line_type [WAYS-1:0]        rd_data,
   input  logic                       wr_en,
   input  logic [AW-1:0]              wr_addr,
   input  line_type [WAYS-1:0]        wr_data
);

   line_type [WAYS-1:0] mem [DEPTH];
   line_type [WAYS-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// File: design/salc_way_select.sv
module salc_way_select
   import salc_pkg::*;
#(
   parameter int MAX_WAYS = DEF_MAX_WAYS,
   localparam int WCNT_W = $clog2(MAX_WAYS + 1)
) (
   input  line_type [MAX_WAYS-1:0] row_in,
   input  logic [TAG_W-1:0]        lookup_tag,
   input  logic [STAMP_W-1:0]      stamp_now,
   input  logic [WCNT_W-1:0]       ways_eff,
   output line_type [MAX_WAYS-1:0] row_out,
   output sel_type                 status
);

   localparam int LVL = (MAX_WAYS > 1) ? $clog2(MAX_WAYS) : 0;
   localparam int NP  = 1 << LVL;
   localparam int VW  = (LVL > 0) ? LVL : 1;

   logic [MAX_WAYS-1:0] way_en;
   logic [MAX_WAYS-1:0] match;
   logic [MAX_WAYS-1:0] inval;
   logic [MAX_WAYS-1:0] live;
   logic [MAX_WAYS-1:0] hit_oh;
   logic [MAX_WAYS-1:0] free_oh;
   logic [MAX_WAYS-1:0] victim_oh;
   logic [MAX_WAYS-1:0] slot_oh;
   logic                hit;
   logic                any_free;

   // max-age tree, heap layout; left child wins ties (lower way)
   logic               node_vld [2*NP-1];
   logic [STAMP_W-1:0] node_age [2*NP-1];
   logic [VW-1:0]      node_idx [2*NP-1];

   always_comb begin
      for (int w = 0; w < MAX_WAYS; w++) begin
         way_en[w] = (WCNT_W'(w) < ways_eff);
         match[w]  = way_en[w] && row_in[w].valid && (row_in[w].tag == lookup_tag);
         inval[w]  = way_en[w] && !row_in[w].valid;
         live[w]   = way_en[w] && row_in[w].valid;
      end
   end

   always_comb begin
      for (int i = 0; i < 2*NP-1; i++) begin
         node_vld[i] = 1'b0;
         node_age[i] = '0;
         node_idx[i] = '0;
      end
      for (int i = 0; i < MAX_WAYS; i++) begin
         node_vld[NP-1+i] = live[i];
         node_age[NP-1+i] = stamp_now - row_in[i].stamp;
         node_idx[NP-1+i] = VW'(i);
      end
      for (int n = NP-2; n >= 0; n--) begin
         if (node_vld[2*n+1] &&
             (!node_vld[2*n+2] || node_age[2*n+1] >= node_age[2*n+2])) begin
            node_age[n] = node_age[2*n+1];
            node_idx[n] = node_idx[2*n+1];
         end else begin
            node_age[n] = node_age[2*n+2];
            node_idx[n] = node_idx[2*n+2];
         end
         node_vld[n] = node_vld[2*n+1] || node_vld[2*n+2];
      end
   end

   always_comb begin
      for (int w = 0; w < MAX_WAYS; w++) begin
         victim_oh[w] = (node_idx[0] == VW'(w));
      end
   end

   assign hit_oh   = match & (~match + MAX_WAYS'(1));
   assign free_oh  = inval & (~inval + MAX_WAYS'(1));
   assign hit      = |match;
   assign any_free = |inval;

   always_comb begin
      priority if (hit) begin
         slot_oh = hit_oh;
      end else if (any_free) begin
         slot_oh = free_oh;
      end else begin
         slot_oh = victim_oh;
      end
   end

   always_comb begin
      for (int w = 0; w < MAX_WAYS; w++) begin
         row_out[w] = row_in[w];
         if (slot_oh[w]) begin
            row_out[w].valid = 1'b1;
            row_out[w].tag   = lookup_tag;
            row_out[w].stamp = stamp_now;
         end
      end
   end

   assign status = '{hit: hit, evicted: !hit && !any_free};

endmodule
